/* hdl/keyed_registry_table_macros.svh */
// assertion helpers used by keyed_registry_table.sv
// both macros use the clk and rst of the module they stand in
`ifndef KEYED_REGISTRY_TABLE_MACROS_SVH
`define KEYED_REGISTRY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

`define KRT_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("keyed registry table check failed");

`define KRT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("keyed registry table check failed");

`else

`define KRT_ASSERT_IMPLY(label, cond, prop)

`define KRT_ASSERT_NEXT(label, cond, prop)

`endif

`endif

/* hdl/krt_pkg.sv */
package krt_pkg;

  localparam int KEY_W    = 32;
  localparam int TYPE_W   = 8;
  localparam int SIZE_W   = 31;
  localparam int HANDLE_W = 64;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic REQ_LOOKUP   = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  // request word walking down the chain of cells
  typedef struct packed {
    logic                valid;
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [TYPE_W-1:0]   etype;
    logic [SIZE_W-1:0]   esize;
    logic [HANDLE_W-1:0] ehandle;
    logic                hit;
    logic                stored;
    logic [SLOT_W-1:0]   slot;
  } word_t;

endpackage

/* hdl/krt_cell.sv */
module krt_cell #(
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  krt_pkg::word_t word_in,
  output krt_pkg::word_t word_out,
  output logic          entry_valid
);
  import krt_pkg::*;

  logic [KEY_W-1:0]    key;
  logic [TYPE_W-1:0]   etype;
  logic [SIZE_W-1:0]   esize;
  logic [HANDLE_W-1:0] ehandle;
  logic                hit_now;
  logic                store_now;
  word_t               word_next;

  assign hit_now = word_in.valid && !word_in.hit && entry_valid && (key == word_in.key);

  // entries fill in order, so the first empty cell is the next free slot
  assign store_now = word_in.valid && (word_in.req_type == REQ_REGISTER) &&
                     !word_in.hit && !word_in.stored && !entry_valid;

  always_comb begin
    word_next = word_in;
    if (hit_now) begin
      word_next.hit     = 1'b1;
      word_next.slot    = SLOT_W'(INDEX);
      word_next.etype   = etype;
      word_next.esize   = esize;
      word_next.ehandle = ehandle;
    end else if (store_now) begin
      word_next.stored = 1'b1;
      word_next.slot   = SLOT_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= 1'b0;
      word_out.valid <= 1'b0;
    end else if (adv) begin
      word_out.valid <= word_next.valid;
      if (store_now) begin
        entry_valid <= 1'b1;
      end
    end
    if (adv) begin
      word_out.req_type <= word_next.req_type;
      word_out.key      <= word_next.key;
      word_out.etype    <= word_next.etype;
      word_out.esize    <= word_next.esize;
      word_out.ehandle  <= word_next.ehandle;
      word_out.hit      <= word_next.hit;
      word_out.stored   <= word_next.stored;
      word_out.slot     <= word_next.slot;
      if (store_now) begin
        key     <= word_in.key;
        etype   <= word_in.etype;
        esize   <= word_in.esize;
        ehandle <= word_in.ehandle;
      end
    end
  end

endmodule

/* hdl/keyed_registry_table.sv */
// Append-only keyed registry. Each request word walks through a chain of
// CAPACITY cells, one cell per cycle unless the chain holds, each cell
// holding one entry; a lookup picks up the first matching entry on the way,
// a register request is rejected as a duplicate on a match or is written
// into the first empty cell it meets (table full if there is none). One
// request is in the chain at a time: the result of a request is registered
// once the word leaves the last cell, and the next request can be accepted
// in the cycle after that. The result sits in an output register, and the
// next request is accepted while it waits to be taken; if it is still
// waiting when the next word reaches the end of the chain, the whole chain
// holds.
`include "keyed_registry_table_macros.svh"

module keyed_registry_table #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic signed [krt_pkg::KEY_W-1:0] identifier,
  input  logic [krt_pkg::TYPE_W-1:0]      entry_type,
  input  logic [krt_pkg::SIZE_W-1:0]      entry_size,
  input  logic [krt_pkg::HANDLE_W-1:0]    entry_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [krt_pkg::STATUS_W-1:0]    status,
  output logic [krt_pkg::SLOT_W-1:0]      slot_index,
  output logic [krt_pkg::TYPE_W-1:0]      found_type,
  output logic [krt_pkg::SIZE_W-1:0]      found_size,
  output logic [krt_pkg::HANDLE_W-1:0]    found_handle
);
  import krt_pkg::*;

  word_t               words [0:CAPACITY];
  logic [CAPACITY-1:0] entry_valid;
  logic [CAPACITY:0]   word_valids;
  logic                busy;
  logic                adv;
  logic                in_accept;
  logic                tail_done;
  logic                res_ok;
  logic [STATUS_W-1:0] res_status;
  word_t               head;
  word_t               tail;

  assign in_accept = in_valid && in_ready;
  assign in_ready  = !busy;
  assign words[0]  = head;
  assign tail      = words[CAPACITY];

  // the whole chain holds while a finished word cannot leave
  assign adv       = !(tail.valid && out_valid && !out_ready);
  assign tail_done = tail.valid && adv;

  always_comb begin
    head          = '0;
    head.valid    = in_accept;
    head.req_type = req_type;
    head.key      = identifier;
    head.etype    = entry_type;
    head.esize    = entry_size;
    head.ehandle  = entry_handle;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_chain
      krt_cell #(.INDEX(g)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .word_in    (words[g]),
        .word_out   (words[g+1]),
        .entry_valid(entry_valid[g])
      );
    end
    for (g = 0; g <= CAPACITY; g++) begin : g_wv
      assign word_valids[g] = words[g].valid;
    end
  endgenerate

  always_comb begin
    if (tail.req_type == REQ_LOOKUP) begin
      res_status = tail.hit ? ST_OK : ST_NOT_FOUND;
    end else if (tail.hit) begin
      res_status = ST_DUPLICATE;
    end else begin
      res_status = tail.stored ? ST_OK : ST_FULL;
    end
  end

  assign res_ok = (res_status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        busy <= 1'b1;
      end else if (tail_done) begin
        busy <= 1'b0;
      end
      if (tail_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_done) begin
      status       <= res_status;
      slot_index   <= res_ok ? tail.slot : '0;
      found_type   <= res_ok ? tail.etype : '0;
      found_size   <= res_ok ? tail.esize : '0;
      found_handle <= res_ok ? tail.ehandle : '0;
    end
  end

  // filled cells always form an unbroken run from slot 0
  `KRT_ASSERT_IMPLY(a_fill_contiguous, 1'b1,
                    (entry_valid & (entry_valid + CAPACITY'(1))) == '0)
  `KRT_ASSERT_IMPLY(a_single_word, 1'b1, $onehot0(word_valids))
  `KRT_ASSERT_IMPLY(a_enter_empty, in_accept, word_valids[CAPACITY:1] == '0)
  `KRT_ASSERT_NEXT(a_result_lands, tail_done, out_valid && !busy)

endmodule
